// ----- src/bdeq_pkg.sv -----
// ============================================================================
// bdeq_pkg: shared types and constants of the bounded deque
// Request and status codes, controller states and the controller commands.
// ============================================================================
package bdeq_pkg;

    localparam int VAL_W = 64;
    localparam int CAP_W = 11;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    typedef enum logic [2:0] {
        REQ_PUSH_BACK  = 3'd0,
        REQ_PUSH_FRONT = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_CLEAR      = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_RESP = 2'd2
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // latch the request fields
        logic exec;     // perform the store access and update the pointers
    } t_cmd;

endpackage

// ----- src/bdeq_ctrl.sv -----
// ============================================================================
// bdeq_ctrl: request sequencer of the bounded deque
// Walks each transaction through capture, execution and result cycles.
// ============================================================================
module bdeq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output bdeq_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    bdeq_pkg::t_state r_state;
    bdeq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bdeq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.exec    = 1'b0;
        o_busy        = 1'b1;
        o_done        = 1'b0;
        unique case (r_state)
            bdeq_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = bdeq_pkg::S_EXEC;
                end
            end
            bdeq_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = bdeq_pkg::S_RESP;
            end
            bdeq_pkg::S_RESP: begin
                o_done  = 1'b1;
                n_state = bdeq_pkg::S_IDLE;
            end
            default: begin
                n_state = bdeq_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- src/bdeq_datapath.sv -----
// ============================================================================
// bdeq_datapath: circular store and pointers of the bounded deque
// Holds the entry memory, front index, count and capacity register.
// ============================================================================
module bdeq_datapath #(
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bdeq_pkg::t_cmd                       i_cmd,
    input  logic [2:0]                           i_req_type,
    input  logic signed [bdeq_pkg::VAL_W-1:0]    i_push_value,
    input  logic                                 i_cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]           i_cfg_wdata,
    output logic signed [bdeq_pkg::VAL_W-1:0]    o_pop_value,
    output logic [1:0]                           o_status,
    output logic [bdeq_pkg::CAP_W-1:0]           o_entry_count,
    output logic                                 o_is_full,
    output logic                                 o_is_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > bdeq_pkg::CAP_W) ? CW : bdeq_pkg::CAP_W;

    logic [bdeq_pkg::VAL_W-1:0] mem [DEPTH];

    bdeq_pkg::t_req             r_req;
    logic [bdeq_pkg::VAL_W-1:0] r_val;
    logic [AW-1:0]              r_front;
    logic [CW-1:0]              r_count;
    logic [bdeq_pkg::CAP_W-1:0] r_cap;
    bdeq_pkg::t_status          r_status;
    logic                       r_pop_ok;
    logic [bdeq_pkg::VAL_W-1:0] r_rdata;

    logic [AW-1:0]              n_front;
    logic [CW-1:0]              n_count;
    bdeq_pkg::t_status          n_status;
    logic                       n_pop_ok;

    logic                       mem_we;
    logic                       mem_re;
    logic [AW-1:0]              mem_addr;

    logic [EW-1:0]              cap_ext;
    logic [EW-1:0]              eff_cap;
    logic [EW-1:0]              count_ext;
    logic                       full;
    logic                       empty;
    logic [CW:0]                sum_back;
    logic [CW:0]                sum_last;
    logic [AW-1:0]              idx_back;
    logic [AW-1:0]              idx_last;
    logic [AW-1:0]              front_dec;
    logic [AW-1:0]              front_inc;

    // Capacity of zero acts as one; above the built depth it acts as the depth.
    always_comb begin
        cap_ext = EW'(r_cap);
        if (cap_ext == '0) begin
            eff_cap = EW'(1);
        end else if (cap_ext > EW'(DEPTH)) begin
            eff_cap = EW'(DEPTH);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign count_ext = EW'(r_count);
    assign full      = (count_ext >= eff_cap);
    assign empty     = (r_count == '0);

    // Circular indexes: each sum stays below twice the depth, one subtract wraps it.
    assign sum_back = (CW+1)'(r_front) + (CW+1)'(r_count);
    assign sum_last = (CW+1)'(r_front) + (CW+1)'(r_count - CW'(1));
    assign idx_back = (sum_back >= (CW+1)'(DEPTH)) ?
                      AW'(sum_back - (CW+1)'(DEPTH)) : AW'(sum_back);
    assign idx_last = (sum_last >= (CW+1)'(DEPTH)) ?
                      AW'(sum_last - (CW+1)'(DEPTH)) : AW'(sum_last);
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : (r_front - AW'(1));
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : (r_front + AW'(1));

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = bdeq_pkg::ST_OK;
        n_pop_ok = 1'b0;
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = r_front;
        unique case (r_req)
            bdeq_pkg::REQ_PUSH_BACK: begin
                mem_addr = idx_back;
                if (full) begin
                    n_status = bdeq_pkg::ST_OVERFLOW;
                end else begin
                    mem_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            bdeq_pkg::REQ_PUSH_FRONT: begin
                mem_addr = front_dec;
                if (full) begin
                    n_status = bdeq_pkg::ST_OVERFLOW;
                end else begin
                    mem_we  = 1'b1;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            bdeq_pkg::REQ_POP_FRONT: begin
                mem_addr = r_front;
                if (empty) begin
                    n_status = bdeq_pkg::ST_UNDERFLOW;
                end else begin
                    mem_re   = 1'b1;
                    n_pop_ok = 1'b1;
                    n_front  = front_inc;
                    n_count  = r_count - CW'(1);
                end
            end
            bdeq_pkg::REQ_POP_BACK: begin
                mem_addr = idx_last;
                if (empty) begin
                    n_status = bdeq_pkg::ST_UNDERFLOW;
                end else begin
                    mem_re   = 1'b1;
                    n_pop_ok = 1'b1;
                    n_count  = r_count - CW'(1);
                end
            end
            bdeq_pkg::REQ_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_cap   <= bdeq_pkg::CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
        end
    end

    // Request fields and per-request results carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= bdeq_pkg::t_req'(i_req_type);
            r_val <= i_push_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_pop_ok <= n_pop_ok;
        end
    end

    // Single-port entry store with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && mem_we) begin
            mem[mem_addr] <= r_val;
        end
        if (i_cmd.exec && mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    assign o_pop_value   = r_pop_ok ? r_rdata : '0;
    assign o_status      = r_status;
    assign o_entry_count = count_ext[bdeq_pkg::CAP_W-1:0];
    assign o_is_full     = full;
    assign o_is_empty    = empty;

endmodule

// ----- src/bounded_double_ended_queue_core.sv -----
// ============================================================================
// bounded_double_ended_queue_core: bounded deque of 64-bit signed values
// Push and pop at either end of a circular store, plus clear.
// ============================================================================
// Usage:
//   A request transaction is taken at a rising edge where i_start is high and
//   o_busy is low; i_req_type selects push back, push front, pop front, pop
//   back or clear, and i_push_value carries the value for a push.
//   Every request returns exactly one result transaction: o_done is high for
//   one cycle with the popped value, the status, the count after the request
//   and the full and empty flags. The receiver cannot stall; results must be
//   taken in the cycle they are shown.
//   The result is shown once the request has passed the execution state, and a
//   new request is taken only after the sequencer has returned to idle.
//   These steps come from the single port of the entry memory: the request
//   is latched, the store is accessed, and then the registered read data is
//   presented.
//   The capacity register (i_cfg_we, i_cfg_wdata) may be written while idle.
//   Reset clears the queue to empty and sets the capacity to 1024; the entry
//   memory itself is not cleared, since only pushed entries are ever read.
// ============================================================================
module bounded_double_ended_queue_core #(
    parameter int DEPTH = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [2:0]                           i_req_type,
    input  logic signed [bdeq_pkg::VAL_W-1:0]    i_push_value,
    input  logic                                 i_cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]           i_cfg_wdata,
    output logic                                 o_busy,
    output logic                                 o_done,
    output logic signed [bdeq_pkg::VAL_W-1:0]    o_pop_value,
    output logic [1:0]                           o_status,
    output logic [bdeq_pkg::CAP_W-1:0]           o_entry_count,
    output logic                                 o_is_full,
    output logic                                 o_is_empty
);

    // Commands from the sequencer to the datapath.
    bdeq_pkg::t_cmd cmd;

    // The sequencer owns the handshake and steps each transaction through.
    bdeq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    // The datapath holds the store, pointers and capacity, and forms results.
    bdeq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

endmodule

// ----- src/bdeq_checker.sv -----
// ============================================================================
// bdeq_checker: port-level checks of the bounded deque
// Result timing and consistency of the reported flags.
// ============================================================================
module bdeq_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_start,
    input logic                              o_busy,
    input logic                              o_done,
    input logic signed [bdeq_pkg::VAL_W-1:0] o_pop_value,
    input logic [1:0]                        o_status,
    input logic                              o_is_full,
    input logic                              o_is_empty
);

    // Every accepted transaction produces its result after its execution state.
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("result did not follow an accepted request");

    // A result is only shown while a transaction is in flight.
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> o_busy)
        else $error("result shown while idle");

    // Capacity is at least one, so a full queue is never empty.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_is_full && o_is_empty))
        else $error("queue reported both full and empty");

    // An underflow leaves an empty queue and returns zero.
    a_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == bdeq_pkg::ST_UNDERFLOW)) |->
        (o_is_empty && (o_pop_value == '0)))
        else $error("underflow with data or non-empty queue");

endmodule

bind bounded_double_ended_queue_core bdeq_checker u_bdeq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .o_done      (o_done),
    .o_pop_value (o_pop_value),
    .o_status    (o_status),
    .o_is_full   (o_is_full),
    .o_is_empty  (o_is_empty)
);

// ----- tb/tb_top.sv -----
// ============================================================================
// tb_top: self-checking testbench for the bounded deque core
// Requests are sent from a queue of pending steps with random spacing. Each
// accepted request is run through a behavioral deque kept in the testbench,
// and every result strobe is compared field by field with the oldest
// prediction. Capacity writes are made only while the core is idle.
// ============================================================================
module tb_top;

    localparam int VAL_W        = bdeq_pkg::VAL_W;
    localparam int CAP_W        = bdeq_pkg::CAP_W;
    localparam int DEPTH        = 1024;
    localparam int ADDR_W       = $clog2(DEPTH);
    // Idle cycles that must pass before a capacity write, and at the end.
    localparam int QUIET_CYCLES = 4;
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    // Request codes above clear are not defined and act as a no-op.
    localparam logic [2:0] REQ_NOP_FIRST = 3'd5;
    localparam logic [2:0] REQ_NOP_LAST  = 3'd7;

    // One result transaction, in the order of the result ports.
    typedef struct packed {
        logic signed [VAL_W-1:0] pop_value;
        bdeq_pkg::t_status       status;
        logic [CAP_W-1:0]        entry_count;
        logic                    is_full;
        logic                    is_empty;
    } t_deque_result;

    // A step is a request, a capacity write, or a pause until the core is idle.
    typedef enum {STEP_REQ, STEP_CFG, STEP_QUIET} t_step_kind;

    typedef struct {
        t_step_kind              kind;
        logic [2:0]              req;
        logic signed [VAL_W-1:0] value;
        logic [CAP_W-1:0]        cap;
        int unsigned             gap;
    } t_deque_step;

    // All inputs start at known values; reset is held low from time zero.
    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_start      = 1'b0;
    logic [2:0]              i_req_type   = bdeq_pkg::REQ_PUSH_BACK;
    logic signed [VAL_W-1:0] i_push_value = '0;
    logic                    i_cfg_we     = 1'b0;
    logic [CAP_W-1:0]        i_cfg_wdata  = bdeq_pkg::CAP_RESET;
    logic                    o_busy;
    logic                    o_done;
    logic signed [VAL_W-1:0] o_pop_value;
    logic [1:0]              o_status;
    logic [CAP_W-1:0]        o_entry_count;
    logic                    o_is_full;
    logic                    o_is_empty;

    t_deque_step   pending_steps[$];
    t_deque_result results_due[$];
    int unsigned   fail_count   = 0;
    int unsigned   gap_left     = 0;
    int unsigned   next_gap     = 0;
    int unsigned   quiet_count  = 0;
    logic          req_taken    = 1'b0;
    bit            steady_sender = 1'b0;

    // Behavioral copy of the deque: a circular store addressed by a head
    // index and a fill count, plus the capacity setting as last written.
    logic signed [VAL_W-1:0] ring [DEPTH];
    logic [ADDR_W-1:0]       ring_head   = '0;
    logic [CAP_W-1:0]        ring_fill   = '0;
    logic [CAP_W-1:0]        cap_setting = bdeq_pkg::CAP_RESET;

    bounded_double_ended_queue_core #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_req_type    (i_req_type),
        .i_push_value  (i_push_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_busy        (o_busy),
        .o_done        (o_done),
        .o_pop_value   (o_pop_value),
        .o_status      (o_status),
        .o_entry_count (o_entry_count),
        .o_is_full     (o_is_full),
        .o_is_empty    (o_is_empty)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one request to the behavioral deque and returns its result.
    // A capacity of zero acts as one and anything above the depth acts as
    // the depth. A full check uses >= so that a capacity lowered below the
    // current count keeps the queue full until enough entries are popped.
    function automatic t_deque_result apply_request(logic [2:0] req,
                                                    logic signed [VAL_W-1:0] value);
        t_deque_result     res;
        logic [CAP_W-1:0]  limit;
        logic [ADDR_W-1:0] pos;
        logic              was_full;
        if (cap_setting == '0) begin
            limit = CAP_W'(1);
        end else if (cap_setting > DEPTH) begin
            limit = CAP_W'(DEPTH);
        end else begin
            limit = cap_setting;
        end
        was_full      = (ring_fill >= limit);
        res.pop_value = '0;
        res.status    = bdeq_pkg::ST_OK;
        case (req)
            bdeq_pkg::REQ_PUSH_BACK: begin
                if (was_full) begin
                    res.status = bdeq_pkg::ST_OVERFLOW;
                end else begin
                    pos       = ring_head + ring_fill[ADDR_W-1:0];
                    ring[pos] = value;
                    ring_fill++;
                end
            end
            bdeq_pkg::REQ_PUSH_FRONT: begin
                if (was_full) begin
                    res.status = bdeq_pkg::ST_OVERFLOW;
                end else begin
                    ring_head       = ring_head - 1'b1;
                    ring[ring_head] = value;
                    ring_fill++;
                end
            end
            bdeq_pkg::REQ_POP_FRONT: begin
                if (ring_fill == '0) begin
                    res.status = bdeq_pkg::ST_UNDERFLOW;
                end else begin
                    res.pop_value = ring[ring_head];
                    ring_head     = ring_head + 1'b1;
                    ring_fill--;
                end
            end
            bdeq_pkg::REQ_POP_BACK: begin
                if (ring_fill == '0) begin
                    res.status = bdeq_pkg::ST_UNDERFLOW;
                end else begin
                    // With the store completely full the low bits of the
                    // count are zero, and the subtraction still wraps to the
                    // slot just before the head.
                    pos           = ring_head + ring_fill[ADDR_W-1:0] - 1'b1;
                    res.pop_value = ring[pos];
                    ring_fill--;
                end
            end
            bdeq_pkg::REQ_CLEAR: begin
                ring_head = '0;
                ring_fill = '0;
            end
            default: begin
            end
        endcase
        res.entry_count = ring_fill;
        res.is_full     = (ring_fill >= limit);
        res.is_empty    = (ring_fill == '0);
        return res;
    endfunction

    task automatic check_field(string field, logic signed [VAL_W-1:0] want,
                               logic signed [VAL_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
            fail_count++;
        end
    endtask

    // Driver. Inputs change on the falling edge only. A request stays on the
    // ports until a rising edge takes it (start high, busy low); after that
    // the sender idles for the gap drawn for that request. With a gap of zero
    // the next request goes out at once, so start simply stays high.
    always @(negedge i_clk) begin
        t_deque_step step;
        logic        start_nx;
        logic        we_nx;
        if (i_rst_n) begin
            start_nx = i_start && !req_taken;
            we_nx    = 1'b0;
            if (i_start && req_taken) begin
                gap_left = next_gap;
            end
            if (!start_nx && gap_left != 0) begin
                gap_left--;
            end else if (!start_nx && pending_steps.size() != 0) begin
                step = pending_steps[0];
                case (step.kind)
                    STEP_REQ: begin
                        void'(pending_steps.pop_front());
                        i_req_type   <= step.req;
                        i_push_value <= step.value;
                        next_gap     = step.gap;
                        start_nx     = 1'b1;
                    end
                    STEP_CFG: begin
                        void'(pending_steps.pop_front());
                        i_cfg_wdata <= step.cap;
                        we_nx       = 1'b1;
                    end
                    STEP_QUIET: begin
                        // Hold off until every predicted result has come
                        // back and the core has stayed idle long enough to reach the quiet count.
                        if (results_due.size() != 0 || o_busy) begin
                            quiet_count = 0;
                        end else if (quiet_count == QUIET_CYCLES) begin
                            void'(pending_steps.pop_front());
                            quiet_count = 0;
                        end else begin
                            quiet_count++;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            i_start  <= start_nx;
            i_cfg_we <= we_nx;
        end
    end

    // Monitor. Everything is sampled on the rising edge. A result strobe is
    // checked before the request taken at the same edge is predicted; since
    // a result only follows its request's execution state, a strobe can never
    // belong to the request taken at the same edge.
    always @(posedge i_clk) begin
        t_deque_result seen;
        t_deque_result want;
        if (!i_rst_n) begin
            req_taken <= 1'b0;
        end else begin
            if (o_done) begin
                seen.pop_value   = o_pop_value;
                seen.status      = bdeq_pkg::t_status'(o_status);
                seen.entry_count = o_entry_count;
                seen.is_full     = o_is_full;
                seen.is_empty    = o_is_empty;
                if (results_due.size() == 0) begin
                    $display("%0t: result mismatch, expected none, got value %0d count %0d",
                             $time, seen.pop_value, seen.entry_count);
                    fail_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("pop_value", want.pop_value, seen.pop_value);
                    check_field("status", VAL_W'(want.status), VAL_W'(seen.status));
                    check_field("entry_count", VAL_W'(want.entry_count),
                                VAL_W'(seen.entry_count));
                    check_field("is_full", VAL_W'(want.is_full), VAL_W'(seen.is_full));
                    check_field("is_empty", VAL_W'(want.is_empty), VAL_W'(seen.is_empty));
                end
            end
            if (i_cfg_we) begin
                cap_setting = i_cfg_wdata;
            end
            if (i_start && !o_busy) begin
                results_due.push_back(apply_request(i_req_type, i_push_value));
            end
            req_taken <= i_start && !o_busy;
        end
    end

    // Values lean toward the extremes of the signed range now and then.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            3:       return -64'sd1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic queue_request(logic [2:0] req, logic signed [VAL_W-1:0] value);
        t_deque_step step;
        step.kind  = STEP_REQ;
        step.req   = req;
        step.value = value;
        step.cap   = '0;
        step.gap   = steady_sender ? 0 : $urandom_range(0, 7);
        pending_steps.push_back(step);
    endtask

    task automatic queue_pause();
        t_deque_step step;
        step.kind  = STEP_QUIET;
        step.req   = bdeq_pkg::REQ_PUSH_BACK;
        step.value = '0;
        step.cap   = '0;
        step.gap   = 0;
        pending_steps.push_back(step);
    endtask

    // The capacity register may only change while no transaction is open.
    task automatic queue_capacity(logic [CAP_W-1:0] cap);
        t_deque_step step;
        queue_pause();
        step.kind  = STEP_CFG;
        step.req   = bdeq_pkg::REQ_PUSH_BACK;
        step.value = '0;
        step.cap   = cap;
        step.gap   = 0;
        pending_steps.push_back(step);
    endtask

    // Random traffic: push_pct percent pushes at either end, then pops at
    // either end, and a small share of no-op codes and clears.
    task automatic queue_mix(int count, int push_pct);
        int roll;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < push_pct) begin
                queue_request($urandom_range(0, 1) ? bdeq_pkg::REQ_PUSH_FRONT
                                                   : bdeq_pkg::REQ_PUSH_BACK,
                              pick_value());
            end else if (roll < 96) begin
                queue_request($urandom_range(0, 1) ? bdeq_pkg::REQ_POP_FRONT
                                                   : bdeq_pkg::REQ_POP_BACK,
                              pick_value());
            end else if (roll < 98) begin
                queue_request(3'($urandom_range(REQ_NOP_FIRST, REQ_NOP_LAST)), pick_value());
            end else begin
                queue_request(bdeq_pkg::REQ_CLEAR, pick_value());
            end
        end
    endtask

    initial begin
        // Directed opening at the reset capacity: pops on an empty queue, the
        // value extremes at both ends (a push at the front wraps the head to
        // the top of the store), the undefined codes, and clear.
        queue_request(bdeq_pkg::REQ_POP_FRONT, VAL_MAX);
        queue_request(bdeq_pkg::REQ_POP_BACK, VAL_MIN);
        queue_request(bdeq_pkg::REQ_PUSH_BACK, VAL_MAX);
        queue_request(bdeq_pkg::REQ_PUSH_FRONT, VAL_MIN);
        queue_request(bdeq_pkg::REQ_PUSH_BACK, '0);
        queue_request(bdeq_pkg::REQ_PUSH_FRONT, -64'sd1);
        for (int c = REQ_NOP_FIRST; c <= REQ_NOP_LAST; c++) begin
            queue_request(3'(c), pick_value());
        end
        queue_request(bdeq_pkg::REQ_POP_FRONT, '0);
        queue_request(bdeq_pkg::REQ_POP_BACK, '0);
        queue_request(bdeq_pkg::REQ_POP_BACK, '0);
        queue_request(bdeq_pkg::REQ_POP_FRONT, '0);
        queue_request(bdeq_pkg::REQ_POP_FRONT, '0);
        queue_request(bdeq_pkg::REQ_PUSH_BACK, 64'sd1);
        queue_request(bdeq_pkg::REQ_CLEAR, VAL_MAX);
        queue_request(bdeq_pkg::REQ_POP_BACK, '0);
        // Capacity one, then zero, which must behave as one.
        queue_capacity(11'd1);
        queue_request(bdeq_pkg::REQ_PUSH_BACK, pick_value());
        queue_request(bdeq_pkg::REQ_PUSH_FRONT, pick_value());
        queue_request(bdeq_pkg::REQ_POP_BACK, '0);
        queue_request(bdeq_pkg::REQ_POP_BACK, '0);
        queue_capacity(11'd0);
        queue_request(bdeq_pkg::REQ_PUSH_FRONT, pick_value());
        queue_request(bdeq_pkg::REQ_PUSH_BACK, pick_value());
        queue_request(bdeq_pkg::REQ_POP_FRONT, '0);

        // Small capacities with varied push and pop balance, so the queue
        // runs into both full and empty many times.
        repeat (4) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            queue_capacity(11'($urandom_range(2, 16)));
            queue_mix(20, 30 + 20 * $urandom_range(0, 2));
            queue_pause();
        end

        // Fill past a capacity, then lower the capacity below the count.
        steady_sender = 1'b0;
        queue_capacity(11'd12);
        queue_mix(14, 100);
        queue_capacity(11'd3);
        queue_mix(20, 40);

        // An oversized capacity acts as the full depth. Fill the whole store
        // and push a few more to see the drops at the top count.
        queue_capacity(11'd2047);
        for (int n = 0; n < 1040; n++) begin
            if (n % 130 == 0) begin
                steady_sender = $urandom_range(0, 1);
            end
            queue_request($urandom_range(0, 1) ? bdeq_pkg::REQ_PUSH_FRONT
                                               : bdeq_pkg::REQ_PUSH_BACK,
                          pick_value());
        end
        queue_mix(20, 30);
        queue_capacity(11'd1024);
        queue_mix(20, 50);
        queue_capacity(11'd5);
        queue_mix(10, 50);
        queue_request(bdeq_pkg::REQ_CLEAR, pick_value());
        steady_sender = 1'b0;
        queue_capacity(bdeq_pkg::CAP_RESET);
        queue_mix(20, 50);

        // Synchronous reset is held from time zero and released on a falling edge.
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the last transaction to be taken and answered, then give
        // the core a little longer to show any stray result.
        while (pending_steps.size() != 0 || i_start || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * QUIET_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: set far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
